/* src/wrrq_pkg.sv */
// Package with the shared types, codes and reset values of the two-class run queue.
`default_nettype none

package wrrq_pkg;

  // Default number of task slots and the space that a task id can address.
  localparam int MAX_TASKS_DEF = 64;
  localparam int TID_W         = 6;
  localparam int TASK_SPACE    = 1 << TID_W;

  // Field widths of the request and response transactions.
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int SLICE_W  = 16;
  localparam int WEIGHT_W = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PERF_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_WEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TICKS = 2'd2;

  localparam logic [WEIGHT_W-1:0] PERF_WEIGHT_RST = 8'd2;
  localparam logic [WEIGHT_W-1:0] DEF_WEIGHT_RST  = 8'd1;
  localparam logic [SLICE_W-1:0]  SLICE_TICKS_RST = 16'd100;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_YIELD   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PICK    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;

  // Configuration register set.
  typedef struct packed {
    logic [WEIGHT_W-1:0] perf_weight;
    logic [WEIGHT_W-1:0] def_weight;
    logic [SLICE_W-1:0]  slice_ticks;
  } cfg_t;

  // Write enables of the link memories.
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic cls_we;
  } link_we_t;

  // One response transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    picked_task;
    logic                picked_valid;
    logic                resched;
    logic [COUNT_W-1:0]  queued_count;
  } res_t;

endpackage

`default_nettype wire

/* src/wrrq_if.sv */
// Request and response channel interfaces of the two-class run queue.
`default_nettype none

interface wrrq_req_if;
  logic                         valid;
  logic                         ready;
  logic [wrrq_pkg::FUNC_W-1:0]  func;
  logic [wrrq_pkg::TID_W-1:0]   task_id;
  logic                         task_class;

  modport source (output valid, output func, output task_id, output task_class,
                  input ready);
  modport sink   (input valid, input func, input task_id, input task_class,
                  output ready);
endinterface

interface wrrq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [wrrq_pkg::STATUS_W-1:0] status;
  logic [wrrq_pkg::TID_W-1:0]    picked_task;
  logic                          picked_valid;
  logic                          resched;
  logic [wrrq_pkg::COUNT_W-1:0]  queued_count;

  modport source (output valid, output status, output picked_task, output picked_valid,
                  output resched, output queued_count, input ready);
  modport sink   (input valid, input status, input picked_task, input picked_valid,
                  input resched, input queued_count, output ready);
endinterface

`default_nettype wire

/* src/wrrq_link_mem.sv */
// Next-link, previous-link and class memories with one registered read port.
`default_nettype none

module wrrq_link_mem #(
  parameter int MAX_TASKS = wrrq_pkg::MAX_TASKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                            : wrrq_pkg::TASK_SPACE)-1:0] rd_addr,
  input  wire wrrq_pkg::link_we_t  we,
  input  wire logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                            : wrrq_pkg::TASK_SPACE)-1:0] next_waddr,
  input  wire logic [$clog2(MAX_TASKS+1)-1:0] next_wdata,
  input  wire logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                            : wrrq_pkg::TASK_SPACE)-1:0] prev_waddr,
  input  wire logic [$clog2(MAX_TASKS+1)-1:0] prev_wdata,
  input  wire logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                            : wrrq_pkg::TASK_SPACE)-1:0] cls_waddr,
  input  wire logic                cls_wdata,
  output logic [$clog2(MAX_TASKS+1)-1:0] rd_next,
  output logic [$clog2(MAX_TASKS+1)-1:0] rd_prev,
  output logic                     rd_cls
);
  import wrrq_pkg::*;

  localparam int DEPTH   = (MAX_TASKS < TASK_SPACE) ? MAX_TASKS : TASK_SPACE;
  localparam int AW      = $clog2(DEPTH);
  localparam int ENTRIES = 1 << AW;
  localparam int LW      = $clog2(MAX_TASKS + 1);

  logic [LW-1:0] next_mem [ENTRIES];
  logic [LW-1:0] prev_mem [ENTRIES];
  logic          cls_mem  [ENTRIES];

  // Writes; each memory takes at most one write per cycle.
  always_ff @(posedge clk) begin
    if (we.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (we.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (we.cls_we) begin
      cls_mem[cls_waddr] <= cls_wdata;
    end
  end

  // Registered read of one task entry; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
      rd_cls  <= cls_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/wrrq_slice_mem.sv */
// Per-task slice usage memory with valid bits so that unwritten entries read as zero.
`default_nettype none

module wrrq_slice_mem #(
  parameter int MAX_TASKS = wrrq_pkg::MAX_TASKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic rd_en,
  input  wire logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                            : wrrq_pkg::TASK_SPACE)-1:0] rd_addr,
  input  wire logic we,
  input  wire logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                            : wrrq_pkg::TASK_SPACE)-1:0] wr_addr,
  input  wire logic [wrrq_pkg::SLICE_W-1:0] wr_data,
  output logic [wrrq_pkg::SLICE_W-1:0] rd_data
);
  import wrrq_pkg::*;

  localparam int DEPTH   = (MAX_TASKS < TASK_SPACE) ? MAX_TASKS : TASK_SPACE;
  localparam int AW      = $clog2(DEPTH);
  localparam int ENTRIES = 1 << AW;

  logic [SLICE_W-1:0] slice_mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  logic [SLICE_W-1:0] rd_word;
  logic               rd_written;

  // Storage and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      slice_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= slice_mem[rd_addr];
    end
  end

  // Valid bits, cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  // An entry never written counts as zero usage.
  assign rd_data = rd_written ? rd_word : '0;

endmodule

`default_nettype wire

/* src/wrrq_ctrl.sv */
// Sequencer of the run queue: list heads and tails, credits, flags and response register.
`default_nettype none

module wrrq_ctrl #(
  parameter int MAX_TASKS = wrrq_pkg::MAX_TASKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wrrq_pkg::cfg_t      cfg,
  wrrq_req_if.sink                 req,
  wrrq_rsp_if.source               rsp,
  // Memory read side.
  output logic                     rd_en,
  output logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                       : wrrq_pkg::TASK_SPACE)-1:0] rd_addr,
  input  wire logic [$clog2(MAX_TASKS+1)-1:0] rd_next,
  input  wire logic [$clog2(MAX_TASKS+1)-1:0] rd_prev,
  input  wire logic                rd_cls,
  input  wire logic [wrrq_pkg::SLICE_W-1:0] rd_slice,
  // Memory write side.
  output wrrq_pkg::link_we_t       we,
  output logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                       : wrrq_pkg::TASK_SPACE)-1:0] next_waddr,
  output logic [$clog2(MAX_TASKS+1)-1:0] next_wdata,
  output logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                       : wrrq_pkg::TASK_SPACE)-1:0] prev_waddr,
  output logic [$clog2(MAX_TASKS+1)-1:0] prev_wdata,
  output logic [$clog2((MAX_TASKS < wrrq_pkg::TASK_SPACE) ? MAX_TASKS
                       : wrrq_pkg::TASK_SPACE)-1:0] task_waddr,
  output logic                     cls_wdata,
  output logic                     slice_we,
  output logic [wrrq_pkg::SLICE_W-1:0] slice_wdata
);
  import wrrq_pkg::*;

  localparam int DEPTH   = (MAX_TASKS < TASK_SPACE) ? MAX_TASKS : TASK_SPACE;
  localparam int AW      = $clog2(DEPTH);
  localparam int ENTRIES = 1 << AW;
  localparam int LW      = $clog2(MAX_TASKS + 1);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_LINK_A = 5'b00100,
    S_LINK_B = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state;

  // Operation held while it runs.
  logic [FUNC_W-1:0] cur_func;
  logic [TID_W-1:0]  cur_tid;
  logic              cur_cls;
  logic              link_cls, link_cls_next;

  // Queue state in flip-flops.
  logic [LW-1:0]       head [2];
  logic [LW-1:0]       tail [2];
  logic [LW-1:0]       head_next [2];
  logic [LW-1:0]       tail_next [2];
  logic [WEIGHT_W-1:0] perf_credit, perf_credit_next;
  logic [WEIGHT_W-1:0] def_credit, def_credit_next;
  logic [ENTRIES-1:0]  on_queue, on_queue_next;
  logic [CW-1:0]       total, total_next;

  // Results.
  res_t res, res_next, out_res;
  logic out_vld;

  // Step decode.
  logic [AW-1:0]  t_addr;
  logic [LW-1:0]  t_link;
  logic           in_range;
  logic           onq_t;
  logic           do_unlink, do_link_a, do_link_b;
  logic           la_cls;
  logic           cls_we;
  logic           to_link_a, to_link_b, fin_exec;
  logic           has_def, has_perf, pick_q;
  logic [SLICE_W:0] used;
  logic           expire;
  logic           finish, slot_free, load;
  logic           accept;

  assign t_addr   = cur_tid[AW-1:0];
  assign t_link   = LW'(t_addr);
  assign in_range = 32'(cur_tid) < 32'(MAX_TASKS);
  assign onq_t    = on_queue[t_addr];
  assign has_def  = head[0] != NIL;
  assign has_perf = head[1] != NIL;
  assign used     = {1'b0, rd_slice} + {{SLICE_W{1'b0}}, 1'b1};
  assign expire   = used >= {1'b0, cfg.slice_ticks};

  // Requests are taken only between operations, so a memory read never meets a write.
  assign req.ready = (state == S_IDLE);
  assign accept    = (state == S_IDLE) && req.valid;
  assign rd_en     = accept;
  assign rd_addr   = req.task_id[AW-1:0];

  // Decide what the current step does.
  always_comb begin
    do_unlink     = 1'b0;
    do_link_a     = 1'b0;
    do_link_b     = 1'b0;
    to_link_a     = 1'b0;
    to_link_b     = 1'b0;
    fin_exec      = 1'b0;
    la_cls        = link_cls;
    link_cls_next = link_cls;
    cls_we        = 1'b0;
    slice_we      = 1'b0;
    slice_wdata   = '0;
    pick_q        = 1'b0;
    perf_credit_next = perf_credit;
    def_credit_next  = def_credit;
    on_queue_next = on_queue;
    total_next    = total;
    res_next      = '0;
    res_next.status = ST_DONE;

    unique case (state)
      S_EXEC: begin
        fin_exec = 1'b1;
        unique case (cur_func)
          FUNC_ENQUEUE: begin
            if (!in_range || onq_t) begin
              res_next.status = ST_NOT_QUEUED;
            end else begin
              cls_we        = 1'b1;
              do_link_a     = 1'b1;
              la_cls        = cur_cls;
              link_cls_next = cur_cls;
              on_queue_next[t_addr] = 1'b1;
              total_next    = total + CW'(1);
              to_link_b     = 1'b1;
              fin_exec      = 1'b0;
            end
          end
          FUNC_DEQUEUE: begin
            if (!in_range || !onq_t) begin
              res_next.status = ST_NOT_QUEUED;
            end else begin
              do_unlink = 1'b1;
              on_queue_next[t_addr] = 1'b0;
              total_next = total - CW'(1);
            end
          end
          FUNC_YIELD: begin
            if (!in_range || !onq_t) begin
              res_next.status = ST_NOT_QUEUED;
            end else begin
              do_unlink     = 1'b1;
              link_cls_next = rd_cls;
              to_link_a     = 1'b1;
              fin_exec      = 1'b0;
            end
          end
          FUNC_PICK: begin
            if (!has_def && !has_perf) begin
              res_next.status = ST_EMPTY;
            end else begin
              priority if (has_perf && !has_def) begin
                pick_q = 1'b1;
              end else if (has_def && !has_perf) begin
                pick_q = 1'b0;
              end else if (perf_credit != '0) begin
                perf_credit_next = perf_credit - WEIGHT_W'(1);
                pick_q = 1'b1;
              end else begin
                // Default head; the round ends when the default credit runs out.
                if (def_credit <= WEIGHT_W'(1)) begin
                  perf_credit_next = cfg.perf_weight;
                  def_credit_next  = cfg.def_weight;
                end else begin
                  def_credit_next = def_credit - WEIGHT_W'(1);
                end
                pick_q = 1'b0;
              end
              res_next.picked_task  = TID_W'(head[pick_q]);
              res_next.picked_valid = 1'b1;
            end
          end
          FUNC_TICK: begin
            if (!in_range) begin
              res_next.status = ST_NOT_QUEUED;
            end else begin
              slice_we = 1'b1;
              if (expire) begin
                slice_wdata = '0;
                if (onq_t) begin
                  // Requeue only when some other task waits.
                  if (total > CW'(1)) begin
                    do_unlink        = 1'b1;
                    link_cls_next    = rd_cls;
                    res_next.resched = 1'b1;
                    to_link_a        = 1'b1;
                    fin_exec         = 1'b0;
                  end
                end else begin
                  res_next.status  = ST_NOT_QUEUED;
                  res_next.resched = (total != '0);
                end
              end else begin
                slice_wdata = used[SLICE_W-1:0];
                if (!onq_t) begin
                  res_next.status = ST_NOT_QUEUED;
                end
              end
            end
          end
          default: begin
            res_next.status = ST_DONE;
          end
        endcase
      end
      S_LINK_A: begin
        do_link_a = 1'b1;
      end
      S_LINK_B: begin
        do_link_b = 1'b1;
      end
      default: begin
      end
    endcase

    res_next.queued_count = COUNT_W'(total_next);
  end

  // Link memory writes and list end updates.
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    we.next_we   = 1'b0;
    we.prev_we   = 1'b0;
    we.cls_we    = cls_we;
    next_waddr   = t_addr;
    next_wdata   = NIL;
    prev_waddr   = t_addr;
    prev_wdata   = NIL;

    // Remove the task: bridge its neighbors or move the list ends.
    if (do_unlink) begin
      if (rd_prev != NIL) begin
        we.next_we = 1'b1;
        next_waddr = rd_prev[AW-1:0];
        next_wdata = rd_next;
      end else begin
        head_next[rd_cls] = rd_next;
      end
      if (rd_next != NIL) begin
        we.prev_we = 1'b1;
        prev_waddr = rd_next[AW-1:0];
        prev_wdata = rd_prev;
      end else begin
        tail_next[rd_cls] = rd_prev;
      end
    end

    // First half of a tail insert: the task's own links.
    if (do_link_a) begin
      we.prev_we = 1'b1;
      prev_waddr = t_addr;
      prev_wdata = tail[la_cls];
      we.next_we = 1'b1;
      next_waddr = t_addr;
      next_wdata = NIL;
    end

    // Second half: hook the task behind the old tail.
    if (do_link_b) begin
      if (tail[link_cls] != NIL) begin
        we.next_we = 1'b1;
        next_waddr = tail[link_cls][AW-1:0];
        next_wdata = t_link;
      end else begin
        head_next[link_cls] = t_link;
      end
      tail_next[link_cls] = t_link;
    end
  end

  assign task_waddr = t_addr;
  assign cls_wdata  = cur_cls;

  // Response hand-off.
  assign finish    = (state == S_EXEC && fin_exec) || (state == S_LINK_B) || (state == S_RESP);
  assign slot_free = !out_vld || rsp.ready;
  assign load      = finish && slot_free;

  // Captured request fields, step results and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_func <= req.func;
      cur_tid  <= req.task_id;
      cur_cls  <= req.task_class;
    end
    if (state == S_EXEC) begin
      res      <= res_next;
      link_cls <= link_cls_next;
    end
    if (load) begin
      out_res <= (state == S_EXEC) ? res_next : res;
    end
  end

  // Control state and queue state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head[0]     <= NIL;
      head[1]     <= NIL;
      tail[0]     <= NIL;
      tail[1]     <= NIL;
      perf_credit <= PERF_WEIGHT_RST;
      def_credit  <= DEF_WEIGHT_RST;
      on_queue    <= '0;
      total       <= '0;
      out_vld     <= 1'b0;
    end else begin
      head        <= head_next;
      tail        <= tail_next;
      perf_credit <= perf_credit_next;
      def_credit  <= def_credit_next;
      on_queue    <= on_queue_next;
      total       <= total_next;

      if (load) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          priority if (to_link_a) begin
            state <= S_LINK_A;
          end else if (to_link_b) begin
            state <= S_LINK_B;
          end else begin
            state <= load ? S_IDLE : S_RESP;
          end
        end
        S_LINK_A: begin
          state <= S_LINK_B;
        end
        S_LINK_B, S_RESP: begin
          state <= load ? S_IDLE : S_RESP;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.status       = out_res.status;
  assign rsp.picked_task  = out_res.picked_task;
  assign rsp.picked_valid = out_res.picked_valid;
  assign rsp.resched      = out_res.resched;
  assign rsp.queued_count = out_res.queued_count;

endmodule

`default_nettype wire

/* src/two_class_weighted_round_robin_queue_top.sv */
// Top level of the two-class weighted round-robin run queue.
//
//  Channel   Direction  Carries
//  req       in         func, task_id, task_class (valid/ready)
//  rsp       out        status, picked_task, picked_valid, resched, queued_count
//  cfg_*     in         perf_weight, def_weight, slice_ticks writes (index, data)
//
// Dequeue, pick, tick without requeue and failed operations: accept with the link
// memory read, then one read-modify-write step. Enqueue adds an S_LINK_B step, and
// yield or a requeuing tick add S_LINK_A then S_LINK_B, set by the single next-link write port.
// Reset is synchronous and clears list ends, credits, queue flags and slice valid
// bits at once; no clearing pass is needed. A finished result waits in the output
// register while the next request is taken; a second result stalls the sequencer.
`default_nettype none

module two_class_weighted_round_robin_queue_top #(
  parameter int MAX_TASKS = wrrq_pkg::MAX_TASKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [wrrq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wrrq_pkg::CFG_DATA_W-1:0]   cfg_data,
  wrrq_req_if.sink                               req,
  wrrq_rsp_if.source                             rsp
);
  import wrrq_pkg::*;

  localparam int DEPTH = (MAX_TASKS < TASK_SPACE) ? MAX_TASKS : TASK_SPACE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(MAX_TASKS + 1);

  cfg_t cfg;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [LW-1:0]      rd_next, rd_prev;
  logic               rd_cls;
  logic [SLICE_W-1:0] rd_slice;
  link_we_t           we;
  logic [AW-1:0]      next_waddr, prev_waddr, task_waddr;
  logic [LW-1:0]      next_wdata, prev_wdata;
  logic               cls_wdata;
  logic               slice_we;
  logic [SLICE_W-1:0] slice_wdata;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.perf_weight <= PERF_WEIGHT_RST;
      cfg.def_weight  <= DEF_WEIGHT_RST;
      cfg.slice_ticks <= SLICE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERF_WEIGHT: cfg.perf_weight <= cfg_data[WEIGHT_W-1:0];
        CFG_DEF_WEIGHT:  cfg.def_weight  <= cfg_data[WEIGHT_W-1:0];
        CFG_SLICE_TICKS: cfg.slice_ticks <= cfg_data[SLICE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  wrrq_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req         (req),
    .rsp         (rsp),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_next     (rd_next),
    .rd_prev     (rd_prev),
    .rd_cls      (rd_cls),
    .rd_slice    (rd_slice),
    .we          (we),
    .next_waddr  (next_waddr),
    .next_wdata  (next_wdata),
    .prev_waddr  (prev_waddr),
    .prev_wdata  (prev_wdata),
    .task_waddr  (task_waddr),
    .cls_wdata   (cls_wdata),
    .slice_we    (slice_we),
    .slice_wdata (slice_wdata)
  );

  // Link memories.
  wrrq_link_mem #(.MAX_TASKS(MAX_TASKS)) u_link_mem (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .we         (we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .cls_waddr  (task_waddr),
    .cls_wdata  (cls_wdata),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .rd_cls     (rd_cls)
  );

  // Slice usage memory.
  wrrq_slice_mem #(.MAX_TASKS(MAX_TASKS)) u_slice_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .we      (slice_we),
    .wr_addr (task_waddr),
    .wr_data (slice_wdata),
    .rd_data (rd_slice)
  );

endmodule

`default_nettype wire
